// ===== design/fba_pkg.sv =====
// Shared types and codes for the fixed-size block bitmap allocator.
// Depends on nothing; imported by fixed_block_bitmap_allocator_core and the testbench.
`default_nettype none

package fba_pkg;

  // Request opcodes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_ALLOCATED = 3'd0;
  localparam logic [2:0] ST_TOO_LONG  = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_FREED     = 3'd3;
  localparam logic [2:0] ST_UNMATCHED = 3'd4;

  // Configuration register indexes.
  localparam logic REG_BLOCK_SIZE    = 1'b0;
  localparam logic REG_BLOCKS_IN_USE = 1'b1;

  localparam int BITS_PER_WORD = 8;

  typedef struct packed {
    logic        op;
    logic [15:0] request_len;
    logic [23:0] release_offset;
  } fba_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] block_offset;
  } fba_rsp_t;

endpackage

`default_nettype wire

// ===== design/fixed_block_bitmap_allocator_core.sv =====
// Top level of the fixed-size block bitmap allocator: busy map memory and scan engine.
// Depends on fba_pkg for the request and result structs and the status codes.
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  -------------------------------
//  request   start, busy, request                    taken when start && !busy
//  result    done, result                            one-cycle strobe, no back-pressure
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data  written when cfg_valid && cfg_ready
//
// The busy map sits in a memory of 8-bit words, read one word per cycle through a registered
// read port and written back in the cycle its data returns.
// Allocate: words are scanned from word 0 and the result comes with the first word that has a free bit.
// Free: every word in use is visited, so the result comes once the last word in use is checked.
// Too-long requests and requests with no block in use answer in the cycle after the accept.
// After reset a clearing pass writes all MAX_BLOCKS/8 words to zero with busy high.
// The receiver cannot stall results; one item is in work at a time.
`default_nettype none

module fixed_block_bitmap_allocator_core #(
  parameter int MAX_BLOCKS = 256
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  output logic              busy,
  input  wire fba_pkg::fba_req_t request,
  output logic              done,
  output fba_pkg::fba_rsp_t result,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire               cfg_index,
  input  wire [15:0]        cfg_data
);
  import fba_pkg::*;

  localparam int WORDS = MAX_BLOCKS / BITS_PER_WORD;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CW    = $clog2(WORDS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CLEAR = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;

  logic [1:0]    state;
  logic [15:0]   block_size;
  logic [8:0]    blocks_in_use;

  logic [7:0]    mem [WORDS];
  logic [7:0]    rdata;

  logic [CW-1:0] rd_cnt;
  logic [23:0]   rd_base;
  logic          pend;
  logic          pend_last;
  logic [AW-1:0] pend_idx;
  logic [23:0]   pend_base;
  logic          hit_acc;

  logic          op_r;
  logic [23:0]   rel_r;

  logic [CW-1:0] active_words;
  logic [5:0]    cfg_words;
  logic [23:0]   bs8;
  logic [23:0]   lane_start [BITS_PER_WORD];
  logic [7:0]    match;
  logic [2:0]    first_free;
  logic          word_full;
  logic          rd_issue;

  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Blocks in use, capped at the pool size and rounded down to whole words.
  assign cfg_words = blocks_in_use[8:3];
  always_comb begin
    if (32'(cfg_words) > 32'(WORDS)) begin
      active_words = CW'(WORDS);
    end else begin
      active_words = CW'(cfg_words);
    end
  end

  assign bs8 = {5'b0, block_size, 3'b0};

  // Start offsets of the eight blocks in the word being checked, wrapped to 24 bits.
  always_comb begin
    for (int k = 0; k < BITS_PER_WORD; k++) begin
      lane_start[k] = pend_base + 24'(19'(k) * {3'b0, block_size});
      match[k]      = (lane_start[k] == rel_r);
    end
  end

  always_comb begin
    first_free = 3'd0;
    for (int k = BITS_PER_WORD - 1; k >= 0; k--) begin
      if (!rdata[k]) begin
        first_free = 3'(k);
      end
    end
  end

  assign word_full = (rdata == 8'hFF);
  assign rd_issue  = (state == S_SCAN) && (rd_cnt < active_words);

  always_comb begin
    we    = 1'b0;
    waddr = pend_idx;
    wdata = rdata;
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = rd_cnt[AW-1:0];
      wdata = 8'h00;
    end else if (state == S_SCAN && pend) begin
      if (op_r == OP_ALLOC) begin
        we    = !word_full;
        wdata = rdata | (8'h01 << first_free);
      end else begin
        we    = |match;
        wdata = rdata & ~match;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[rd_cnt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      block_size    <= 16'd64;
      blocks_in_use <= 9'd256;
      rd_cnt        <= '0;
      pend          <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BLOCK_SIZE) begin
          block_size <= cfg_data;
        end else begin
          blocks_in_use <= cfg_data[8:0];
        end
      end

      unique case (state)
        S_CLEAR: begin
          rd_cnt <= rd_cnt + 1'b1;
          if (rd_cnt == CW'(WORDS - 1)) begin
            state  <= S_IDLE;
            rd_cnt <= '0;
          end
        end

        S_IDLE: begin
          if (start) begin
            op_r    <= request.op;
            rel_r   <= request.release_offset;
            rd_cnt  <= '0;
            rd_base <= '0;
            hit_acc <= 1'b0;
            pend    <= 1'b0;
            result.block_offset <= '0;
            if (request.op == OP_ALLOC && request.request_len > block_size) begin
              done          <= 1'b1;
              result.status <= ST_TOO_LONG;
            end else if (active_words == '0) begin
              done          <= 1'b1;
              result.status <= (request.op == OP_ALLOC) ? ST_FULL : ST_UNMATCHED;
            end else begin
              state <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (rd_issue) begin
            pend      <= 1'b1;
            pend_idx  <= rd_cnt[AW-1:0];
            pend_base <= rd_base;
            pend_last <= (rd_cnt == active_words - 1'b1);
            rd_cnt    <= rd_cnt + 1'b1;
            rd_base   <= rd_base + bs8;
          end else begin
            pend <= 1'b0;
          end

          if (pend) begin
            if (op_r == OP_ALLOC) begin
              if (!word_full) begin
                done                <= 1'b1;
                result.status       <= ST_ALLOCATED;
                result.block_offset <= lane_start[first_free];
                state               <= S_IDLE;
                pend                <= 1'b0;
              end else if (pend_last) begin
                done                <= 1'b1;
                result.status       <= ST_FULL;
                result.block_offset <= '0;
                state               <= S_IDLE;
                pend                <= 1'b0;
              end
            end else begin
              hit_acc <= hit_acc | (|match);
              if (pend_last) begin
                done                <= 1'b1;
                result.status       <= (hit_acc || (|match)) ? ST_FREED : ST_UNMATCHED;
                result.block_offset <= '0;
                state               <= S_IDLE;
                pend                <= 1'b0;
              end
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Only an allocation carries a nonzero offset.
  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_ALLOCATED |-> result.block_offset == '0)
    else $error("nonzero offset on a result that is not an allocation");

  // An accepted item either answers at once or keeps the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted item neither answered nor started a scan");

  // The busy map is never written while the block is idle.
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !we)
    else $error("busy map written while idle");

  // Read data in flight exists only during a scan.
  a_pend_scan: assert property (@(posedge clk) disable iff (rst)
    pend |-> state == S_SCAN)
    else $error("pending word outside a scan");

endmodule

`default_nettype wire

// ===== dv/fba_tb_pkg.sv =====
// Scoreboard for the fixed-size block bitmap allocator testbench.
// Keeps its own busy map and register copies and checks each result in order.
// Depends on fba_pkg for the request and result structs and the codes.

package fba_tb_pkg;

  import fba_pkg::*;

  localparam int POOL_SLOTS = 256;

  class pool_tracker;

    logic [15:0] blk_size;
    logic [8:0]  blk_count;
    bit          claimed[POOL_SLOTS];
    fba_rsp_t    expected_outcomes[$];
    int          failures;

    function new();
      blk_size  = 16'd64;
      blk_count = 9'd256;
      foreach (claimed[i]) claimed[i] = 1'b0;
      failures  = 0;
    endfunction

    function void write_reg(logic idx, logic [15:0] data);
      if (idx == REG_BLOCK_SIZE) begin
        blk_size = data;
      end else begin
        blk_count = data[8:0];
      end
    endfunction

    // Counts that are not a multiple of eight are rounded down.
    function int active_blocks();
      int n;
      n = blk_count;
      if (n > POOL_SLOTS) n = POOL_SLOTS;
      return n & ~7;
    endfunction

    function logic [23:0] block_start(int idx);
      longint p;
      p = longint'(idx) * longint'(blk_size);
      return p[23:0];
    endfunction

    // Works out the outcome of one accepted item and updates the busy map.
    function void note_request(fba_req_t r);
      fba_rsp_t o;
      int       n;
      bit       hit;
      o = '0;
      n = active_blocks();
      if (r.op == OP_ALLOC) begin
        if (r.request_len > blk_size) begin
          o.status = ST_TOO_LONG;
        end else begin
          o.status = ST_FULL;
          for (int i = 0; i < n; i++) begin
            if (!claimed[i]) begin
              claimed[i]     = 1'b1;
              o.status       = ST_ALLOCATED;
              o.block_offset = block_start(i);
              break;
            end
          end
        end
      end else begin
        // A zero block size puts every block at offset 0, so one free can clear many.
        hit = 1'b0;
        for (int i = 0; i < n; i++) begin
          if (block_start(i) == r.release_offset) begin
            claimed[i] = 1'b0;
            hit        = 1'b1;
          end
        end
        o.status = hit ? ST_FREED : ST_UNMATCHED;
      end
      expected_outcomes.push_back(o);
    endfunction

    function void check_result(fba_rsp_t got);
      fba_rsp_t want;
      if (expected_outcomes.size() == 0) begin
        if (failures < 10)
          $display("ERROR: result with no item outstanding: status %0d offset 0x%06h",
                   got.status, got.block_offset);
        failures++;
        return;
      end
      want = expected_outcomes.pop_front();
      if (got.status !== want.status || got.block_offset !== want.block_offset) begin
        if (failures < 10)
          $display("ERROR: status exp %0d got %0d, block_offset exp 0x%06h got 0x%06h",
                   want.status, got.status, want.block_offset, got.block_offset);
        failures++;
      end
    endfunction

  endclass

endpackage

// ===== dv/tb_top.sv =====
// Top of the block allocator testbench: clock, reset, drivers and stimulus.
// Depends on fba_pkg, fba_tb_pkg and fixed_block_bitmap_allocator_core.

module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import fba_pkg::*;
  import fba_tb_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  fba_req_t    request = '0;
  logic        done;
  fba_rsp_t    result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  pool_tracker pool;
  int          idle_pct = 0;

  fixed_block_bitmap_allocator_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) pool.check_result(result);
      if (start && !busy) pool.note_request(request);
    end
  end

  task automatic send(fba_req_t r);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
  endtask

  // Fields that an operation ignores carry random bits.
  task automatic alloc(logic [15:0] len);
    send(fba_req_t'{op: OP_ALLOC, request_len: len, release_offset: 24'($urandom)});
  endtask

  task automatic release_at(logic [23:0] offset);
    send(fba_req_t'{op: OP_FREE, request_len: 16'($urandom), release_offset: offset});
  endtask

  // Both registers are written once the pool has answered every item.
  task automatic set_pool(logic [15:0] size, logic [15:0] count);
    start <= 1'b0;
    @(posedge clk);
    while (pool.expected_outcomes.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_BLOCK_SIZE;
    cfg_data  <= size;
    do @(posedge clk); while (!cfg_ready);
    pool.write_reg(REG_BLOCK_SIZE, size);
    cfg_index <= REG_BLOCKS_IN_USE;
    cfg_data  <= count;
    do @(posedge clk); while (!cfg_ready);
    pool.write_reg(REG_BLOCKS_IN_USE, count);
    cfg_valid <= 1'b0;
  endtask

  // Mostly legal allocations and frees of claimed blocks, with some noise.
  task automatic random_item();
    int          n;
    int          pick;
    int          idx;
    logic [15:0] size;
    n    = pool.active_blocks();
    size = pool.blk_size;
    pick = $urandom_range(99);
    if (pick < 45) begin
      alloc(16'($urandom_range(size)));
    end else if (pick < 55) begin
      alloc(16'($urandom));
    end else if (pick < 88 && n > 0) begin
      idx = $urandom_range(n - 1);
      repeat (6) if (!pool.claimed[idx]) idx = $urandom_range(n - 1);
      release_at(pool.block_start(idx));
    end else if (pick < 94 && n > 0) begin
      release_at(pool.block_start($urandom_range(n - 1)) + 24'd1);
    end else begin
      release_at(24'($urandom));
    end
  endtask

  initial begin
    logic [15:0] size;
    logic [15:0] count;
    pool = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: 64-byte blocks, 256 of them.
    alloc(16'd0);
    alloc(16'd64);
    alloc(16'd65);
    alloc(16'hFFFF);
    release_at(24'd64);
    release_at(24'd64);
    release_at(24'd32);
    release_at(24'hFFFFFF);
    alloc(16'd1);

    // A count of 13 leaves eight blocks; fill them until the pool is full.
    set_pool(16'hFFFF, 16'd13);
    repeat (7) alloc(16'hFFFF);
    release_at(24'd458745);

    // Fewer than eight blocks means none is in use.
    set_pool(16'd0, 16'd7);
    alloc(16'd0);
    release_at(24'd0);

    // Zero block size: every block starts at 0.
    set_pool(16'd0, 16'd16);
    alloc(16'd1);
    alloc(16'd0);
    release_at(24'd0);
    alloc(16'd0);

    set_pool(16'd1, 16'hFFFF);
    release_at(24'd255);
    alloc(16'd2);
    alloc(16'd1);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin size = 16'd1;                          count = 16'd8;   end
        1: begin size = 16'hFFFF;                       count = 16'hFFFF; end
        2: begin size = 16'($urandom_range(300, 1));    count = 16'd16;  end
        3: begin size = 16'd0;                          count = 16'd24;  end
        4: begin size = 16'd64;                         count = 16'd256; end
        5: begin size = 16'($urandom);                  count = 16'($urandom_range(511)); end
        6: begin size = 16'd3;                          count = 16'd7;   end
        default: begin
          size  = 16'($urandom_range(1000, 1));
          count = 16'($urandom_range(64, 8));
        end
      endcase
      set_pool(size, count);
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 75;
        default: idle_pct = 30;
      endcase
      repeat (50) random_item();
    end

    start <= 1'b0;
    @(posedge clk);
    while (pool.expected_outcomes.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (pool.failures == 0 && pool.expected_outcomes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
